[sv/deq_pkg.sv]
// Package for the double-ended queue: operation codes, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
package deq_pkg;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_HEAD_PUSH   = 3'd0,
    OP_TAIL_PUSH   = 3'd1,
    OP_HEAD_POP    = 3'd2,
    OP_TAIL_POP    = 3'd3,
    OP_HEAD_INDEX  = 3'd4,
    OP_TAIL_INDEX  = 3'd5,
    OP_HEAD_REMOVE = 3'd6,
    OP_TAIL_REMOVE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    ADDR_ACCESS,
    ADDR_SCAN,
    ADDR_NEXT
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      rd_req;
    addr_sel_t addr_sel;
    logic      fin_access;
    logic      scan_miss;
    logic      scan_hit;
    logic      shift_wr;
    logic      fin_remove;
    logic      fail;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_access;
    logic access_ok;
    logic empty;
    logic hit;
    logic scan_last;
    logic shift_more;
  } status_t;

endpackage

[sv/deq_datapath.sv]
// Datapath of the double-ended queue: entry memory, head and count
// registers, search/shift index and result registers.
// Depends on deq_pkg.
module deq_datapath #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  deq_pkg::cmd_t               cmd,
  output deq_pkg::status_t            stat,
  input  logic [deq_pkg::OP_W-1:0]    in_op,
  input  logic [deq_pkg::VALUE_W-1:0] in_value,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  output logic [deq_pkg::VALUE_W-1:0] out_result_data,
  output logic                        out_ok,
  output logic [deq_pkg::LEN_W-1:0]   out_length
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  op_t                  op_r;
  logic [WORD_BITS-1:0] val_r;
  logic [POS_W-1:0]     pos_r;
  logic [AW-1:0]        head_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        idx_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] res_data_r;
  logic                 res_ok_r;

  logic [63:0]          val_ext;
  logic [63:0]          res_ext;
  logic                 head_side;
  logic                 full;
  logic [CW-1:0]        count_m1;
  logic [CW-1:0]        pos_k;
  logic [CW-1:0]        acc_k;
  logic [CW-1:0]        scan_k;
  logic [CW-1:0]        idx_p1;
  logic [CW-1:0]        rd_logic;
  logic [AW-1:0]        rd_slot;
  logic [AW-1:0]        wr_slot;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        head_inc;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] logical);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(logical);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign val_ext   = {32'b0, in_value};
  assign head_side = (op_r == OP_HEAD_POP) || (op_r == OP_HEAD_INDEX) ||
                     (op_r == OP_HEAD_REMOVE);
  assign full      = (count_r == CW'(DEPTH));
  assign count_m1  = count_r - CW'(1);
  assign pos_k     = CW'(pos_r);
  assign scan_k    = head_side ? idx_r : (count_m1 - idx_r);
  assign idx_p1    = idx_r + CW'(1);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : (head_r - AW'(1));
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : (head_r + AW'(1));

  always_comb begin
    unique case (op_r)
      OP_HEAD_POP:   acc_k = '0;
      OP_TAIL_POP:   acc_k = count_m1;
      OP_HEAD_INDEX: acc_k = pos_k;
      OP_TAIL_INDEX: acc_k = count_m1 - pos_k;
      default:       acc_k = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_ACCESS: rd_logic = acc_k;
      ADDR_SCAN:   rd_logic = scan_k;
      ADDR_NEXT:   rd_logic = idx_p1;
      default:     rd_logic = '0;
    endcase
  end

  assign rd_slot = slot_of(head_r, rd_logic);
  assign wr_en   = (cmd.push && !full) || cmd.shift_wr;
  assign wr_data = cmd.push ? val_r : rd_data_r;

  always_comb begin
    if (cmd.shift_wr) begin
      wr_slot = slot_of(head_r, idx_r);
    end else if (op_r == OP_HEAD_PUSH) begin
      wr_slot = head_dec;
    end else begin
      wr_slot = slot_of(head_r, count_r);
    end
  end

  always_comb begin
    stat.is_push    = (op_r == OP_HEAD_PUSH) || (op_r == OP_TAIL_PUSH);
    stat.is_access  = (op_r == OP_HEAD_POP) || (op_r == OP_TAIL_POP) ||
                      (op_r == OP_HEAD_INDEX) || (op_r == OP_TAIL_INDEX);
    stat.empty      = (count_r == '0);
    if ((op_r == OP_HEAD_INDEX) || (op_r == OP_TAIL_INDEX)) begin
      stat.access_ok = LW'(pos_r) < LW'(count_r);
    end else begin
      stat.access_ok = (count_r != '0);
    end
    stat.hit        = (rd_data_r == val_r);
    stat.scan_last  = (idx_p1 == count_r);
    stat.shift_more = (idx_p1 < count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      rd_data_r <= mem[rd_slot];
    end
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      val_r <= val_ext[WORD_BITS-1:0];
      pos_r <= in_position;
    end
    if (cmd.push) begin
      res_data_r <= '0;
      res_ok_r   <= !full;
    end
    if (cmd.fin_access) begin
      res_data_r <= rd_data_r;
      res_ok_r   <= 1'b1;
    end
    if (cmd.fin_remove) begin
      res_data_r <= val_r;
      res_ok_r   <= 1'b1;
    end
    if (cmd.fail) begin
      res_data_r <= '0;
      res_ok_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end
      if (cmd.push && !full) begin
        count_r <= count_r + CW'(1);
        if (op_r == OP_HEAD_PUSH) begin
          head_r <= head_dec;
        end
      end
      if (cmd.fin_access) begin
        if (op_r == OP_HEAD_POP) begin
          head_r  <= head_inc;
          count_r <= count_m1;
        end else if (op_r == OP_TAIL_POP) begin
          count_r <= count_m1;
        end
      end
      if (cmd.scan_miss || cmd.shift_wr) begin
        idx_r <= idx_p1;
      end
      if (cmd.scan_hit) begin
        idx_r <= scan_k;
      end
      if (cmd.fin_remove) begin
        count_r <= count_m1;
      end
    end
  end

  assign res_ext         = 64'(res_data_r);
  assign out_result_data = res_ext[VALUE_W-1:0];
  assign out_ok          = res_ok_r;
  assign out_length      = LEN_W'(count_r);

endmodule

[sv/deq_ctrl.sv]
// Controller state machine of the double-ended queue: sequences push,
// pop, index, search and shift steps and the word handshakes.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  deq_pkg::status_t stat,
  output deq_pkg::cmd_t    cmd
);
  import deq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_ACCESS;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_push) begin
          cmd.push  = 1'b1;
          state_nxt = ST_RESP;
        end else if (stat.is_access) begin
          if (stat.access_ok) begin
            cmd.rd_req   = 1'b1;
            cmd.addr_sel = ADDR_ACCESS;
            state_nxt    = ST_READ;
          end else begin
            cmd.fail  = 1'b1;
            state_nxt = ST_RESP;
          end
        end else if (stat.empty) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_READ: begin
        cmd.fin_access = 1'b1;
        state_nxt      = ST_RESP;
      end
      ST_SCAN_RD: begin
        cmd.rd_req   = 1'b1;
        cmd.addr_sel = ADDR_SCAN;
        state_nxt    = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (stat.hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = ST_SHIFT_RD;
        end else if (stat.scan_last) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          cmd.scan_miss = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.rd_req   = 1'b1;
          cmd.addr_sel = ADDR_NEXT;
          state_nxt    = ST_SHIFT_WR;
        end else begin
          cmd.fin_remove = 1'b1;
          state_nxt      = ST_RESP;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = ST_SHIFT_RD;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/double_ended_queue.sv]
// Double-ended queue of DEPTH words; one request word in, one result word out.
// A new request is accepted only after the previous result has been taken. A pop
// or index read makes one registered memory read unless it fails; a remove compares
// entries until one matches, then moves the entries after it one place toward the
// head. Results hold until taken. Synchronous reset empties the queue; entry
// contents are not cleared.
module double_ended_queue #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [deq_pkg::OP_W-1:0]    in_op,
  input  logic [deq_pkg::VALUE_W-1:0] in_value,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [deq_pkg::VALUE_W-1:0] out_result_data,
  output logic                        out_ok,
  output logic [deq_pkg::LEN_W-1:0]   out_length
);
  import deq_pkg::*;

  cmd_t    cmd;
  status_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_result_data (out_result_data),
    .out_ok          (out_ok),
    .out_length      (out_length)
  );

endmodule
